FILE: rtl/acfc_pkg.sv
package acfc_pkg;

	localparam int BYTE_W     = 8;
	localparam int HIST_DEPTH = 6;
	localparam int DIGIT_W    = 4;
	localparam int CMD_W      = 3;
	localparam int INTERVAL_W = 14;
	localparam int ADDR_W     = 4;
	localparam int ACTION_W   = 2;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [DIGIT_W-1:0]    digit_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [INTERVAL_W-1:0] interval_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [ACTION_W-1:0]   action_t;

	// frame characters
	localparam byte_t CH_END  = 8'h59; // 'Y'
	localparam byte_t CH_SEP  = 8'h58; // 'X'
	localparam byte_t CH_ZERO = 8'd48;
	localparam byte_t CH_NINE = 8'd57;
	localparam byte_t CH_CMD_LO = 8'd49; // '1'
	localparam byte_t CH_CMD_HI = 8'd53; // '5'

	localparam interval_t INTERVAL_RESET = 14'd2000;
	localparam interval_t MAX_REG        = 14'd15;

	// actions requested towards the sensor side
	localparam action_t ACT_NONE = 2'd0;
	localparam action_t ACT_UP   = 2'd1;
	localparam action_t ACT_DOWN = 2'd2;
	localparam action_t ACT_READ = 2'd3;

	// command numbers, taken from the low bits of '1'..'5'
	localparam cmd_t CMD_POWER    = 3'd1;
	localparam cmd_t CMD_LUX      = 3'd2;
	localparam cmd_t CMD_IR       = 3'd3;
	localparam cmd_t CMD_INTERVAL = 3'd4;
	localparam cmd_t CMD_READ     = 3'd5;

	function automatic logic is_digit(byte_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// only meaningful for '0'..'9'
	function automatic digit_t digit_of(byte_t c);
		byte_t d;
		d = c - CH_ZERO;
		return d[DIGIT_W-1:0];
	endfunction

endpackage

FILE: rtl/ascii_command_frame_controller_unit.sv
// ASCII command frame controller. Received serial bytes enter one beat at a
// time on the input channel; the block keeps the six bytes before the current
// one and, whenever a 'Y' arrives, checks the seven-byte frame
// "<cmd> X d d d d Y": command '1'..'5', separator 'X', four ASCII digits.
// A good frame toggles sensor power (1, with a power-up or power-down
// action), toggles lux (2) or infrared (3) reporting, sets the sampling
// interval to the nonzero decimal value (4), or requests a read of sensor
// register 0..15 (5). Every input beat gives exactly one result beat showing
// the flags and interval after that byte. Throughput is one byte per clock;
// each byte passes the input register then the result register, and the
// frame check, the four-digit decimal sum and the state update all sit in
// the single logic stage between them. The result register is refilled in
// the cycle it is taken, so only a held out_ready throttles the input.
module ascii_command_frame_controller_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  acfc_pkg::byte_t           rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      frame_valid,
	output acfc_pkg::action_t         action,
	output acfc_pkg::addr_t           register_address,
	output logic                      sensor_on,
	output logic                      lux_report_on,
	output logic                      ir_report_on,
	output acfc_pkg::interval_t       interval_ms
);
	import acfc_pkg::*;

	// input register
	logic      valid_s1;
	byte_t     byte_s1;

	// frame state
	byte_t     hist_q [HIST_DEPTH];
	logic      power_q;
	logic      lux_q;
	logic      ir_q;
	interval_t interval_q;

	// result register
	logic      out_valid_s2;
	logic      frame_valid_s2;
	action_t   action_s2;
	addr_t     addr_s2;

	// frame decode
	logic      advance;
	logic      cmd_ok;
	logic      digits_ok;
	logic      frame_ok;
	cmd_t      cmd_code;
	interval_t value;
	logic      power_d;
	logic      lux_d;
	logic      ir_d;
	interval_t interval_d;
	action_t   action_d;
	addr_t     addr_d;

	// Move the byte held at the input stage into the result register whenever
	// that register is empty or is being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cmd_ok    = (hist_q[0] >= CH_CMD_LO) && (hist_q[0] <= CH_CMD_HI);
	assign digits_ok = is_digit(hist_q[2]) && is_digit(hist_q[3]) &&
	                   is_digit(hist_q[4]) && is_digit(hist_q[5]);
	assign frame_ok  = (byte_s1 == CH_END) && cmd_ok && (hist_q[1] == CH_SEP)
	                   && digits_ok;
	assign cmd_code  = hist_q[0][CMD_W-1:0];

	// Decimal value of the four digits, oldest digit most significant.
	assign value = INTERVAL_W'(digit_of(hist_q[2])) * INTERVAL_W'(1000)
	             + INTERVAL_W'(digit_of(hist_q[3])) * INTERVAL_W'(100)
	             + INTERVAL_W'(digit_of(hist_q[4])) * INTERVAL_W'(10)
	             + INTERVAL_W'(digit_of(hist_q[5]));

	always_comb begin
		power_d    = power_q;
		lux_d      = lux_q;
		ir_d       = ir_q;
		interval_d = interval_q;
		action_d   = ACT_NONE;
		addr_d     = '0;
		if (frame_ok) begin
			unique case (cmd_code)
				CMD_POWER: begin
					power_d  = !power_q;
					action_d = power_q ? ACT_DOWN : ACT_UP;
				end
				CMD_LUX: begin
					lux_d = !lux_q;
				end
				CMD_IR: begin
					ir_d = !ir_q;
				end
				CMD_INTERVAL: begin
					// a zero interval is ignored
					if (value != '0) begin
						interval_d = value;
					end
				end
				CMD_READ: begin
					// only the sixteen sensor registers are readable
					if (value <= MAX_REG) begin
						action_d = ACT_READ;
						addr_d   = value[ADDR_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the byte until it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state: shift the history and commit the command as the byte
	// moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			power_q    <= 1'b0;
			lux_q      <= 1'b0;
			ir_q       <= 1'b0;
			interval_q <= INTERVAL_RESET;
		end else if (advance) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[HIST_DEPTH-1] <= byte_s1;
			power_q    <= power_d;
			lux_q      <= lux_d;
			ir_q       <= ir_d;
			interval_q <= interval_d;
		end
	end

	// Result register: drop the beat once taken, unless a new one replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_valid_s2 <= frame_ok;
			action_s2      <= action_d;
			addr_s2        <= addr_d;
		end
	end

	// The flag and interval registers change only together with the result
	// register, so they show the state after the beat being presented.
	assign out_valid        = out_valid_s2;
	assign frame_valid      = frame_valid_s2;
	assign action           = action_s2;
	assign register_address = addr_s2;
	assign sensor_on        = power_q;
	assign lux_report_on    = lux_q;
	assign ir_report_on     = ir_q;
	assign interval_ms      = interval_q;

endmodule

FILE: sim/tb_ascii_command_frame_controller_unit.sv
`timescale 1ns / 1ps

module tb_ascii_command_frame_controller_unit;

	import acfc_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_LEN   = 11;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN_WAIT  = 10;
	localparam int FRAME_DIGITS = 4;
	localparam int NO_BAD_DIGIT = FRAME_DIGITS;

	// one result beat as the block presents it
	typedef struct packed {
		logic      frame_valid;
		action_t   action;
		addr_t     register_address;
		logic      sensor_on;
		logic      lux_report_on;
		logic      ir_report_on;
		interval_t interval_ms;
	} ctrl_result_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	byte_t     rx_byte;
	logic      out_valid;
	logic      out_ready;
	logic      frame_valid;
	action_t   action;
	addr_t     register_address;
	logic      sensor_on;
	logic      lux_report_on;
	logic      ir_report_on;
	interval_t interval_ms;

	// predictor state: the six bytes before the current one, oldest first,
	// plus the sensor flags and the sampling interval
	byte_t     rx_hist [HIST_DEPTH] = '{default: '0};
	logic      pwr_state      = 1'b0;
	logic      lux_state      = 1'b0;
	logic      ir_state       = 1'b0;
	interval_t interval_state = INTERVAL_RESET;

	ctrl_result_t results_due [$];

	bit idle_on   = 1'b0;
	bit hold_req  = 1'b0;

	int unsigned bytes_sent   = 0;
	int unsigned bytes_taken  = 0;
	int unsigned results_seen = 0;
	int unsigned good_frames  = 0;
	int unsigned reg_reads    = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches   = 0;

	ascii_command_frame_controller_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.frame_valid      (frame_valid),
		.action           (action),
		.register_address (register_address),
		.sensor_on        (sensor_on),
		.lux_report_on    (lux_report_on),
		.ir_report_on     (ir_report_on),
		.interval_ms      (interval_ms)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Generous watchdog limit, far beyond the slowest good run.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Work out the result of one accepted byte and advance the frame state.
	// A 'Y' closes a frame over the six bytes before it; anything short of
	// a proper "<cmd> X dddd" leaves the flags and interval untouched.
	function automatic ctrl_result_t predict_byte(byte_t b);
		ctrl_result_t r;
		logic         good;
		int unsigned  value;
		cmd_t         cmd_no;
		r     = '0;
		value = 0;
		if (b == CH_END) begin
			good = (rx_hist[0] >= CH_CMD_LO) && (rx_hist[0] <= CH_CMD_HI) &&
				(rx_hist[1] == CH_SEP);
			for (int k = 2; k < HIST_DEPTH; k++) begin
				if ((rx_hist[k] < CH_ZERO) || (rx_hist[k] > CH_NINE))
					good = 1'b0;
				value = value * 10 + (rx_hist[k] - CH_ZERO);
			end
			if (good) begin
				r.frame_valid = 1'b1;
				cmd_no = cmd_t'(rx_hist[0] - CH_ZERO);
				case (cmd_no)
					CMD_POWER: begin
						pwr_state = ~pwr_state;
						r.action  = pwr_state ? ACT_UP : ACT_DOWN;
					end
					CMD_LUX: begin
						lux_state = ~lux_state;
					end
					CMD_IR: begin
						ir_state = ~ir_state;
					end
					CMD_INTERVAL: begin
						// a zero interval is ignored
						if (value != 0)
							interval_state = interval_t'(value);
					end
					CMD_READ: begin
						if (value <= MAX_REG) begin
							r.action           = ACT_READ;
							r.register_address = addr_t'(value);
						end
					end
					default: begin
					end
				endcase
			end
		end
		for (int k = 0; k < HIST_DEPTH - 1; k++)
			rx_hist[k] = rx_hist[k + 1];
		rx_hist[HIST_DEPTH - 1] = b;
		r.sensor_on     = pwr_state;
		r.lux_report_on = lux_state;
		r.ir_report_on  = ir_state;
		r.interval_ms   = interval_state;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			$display("MISMATCH %s: got %0h, expected %0h (result %0d, t=%0t)",
				what, got, want, results_seen, $time);
			mismatches++;
		end
	endtask

	// Check each result beat against the oldest expectation, then queue the
	// expectation for any byte taken at this edge. One process does both, so
	// the order of the two never depends on the scheduler.
	always @(posedge clk) begin : result_check
		ctrl_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					report_mismatch("result beat with nothing expected", 1, 0);
				end else begin
					want = results_due.pop_front();
					report_mismatch("frame_valid", 32'(frame_valid),
						32'(want.frame_valid));
					report_mismatch("action", 32'(action), 32'(want.action));
					report_mismatch("register_address", 32'(register_address),
						32'(want.register_address));
					report_mismatch("sensor_on", 32'(sensor_on), 32'(want.sensor_on));
					report_mismatch("lux_report_on", 32'(lux_report_on),
						32'(want.lux_report_on));
					report_mismatch("ir_report_on", 32'(ir_report_on),
						32'(want.ir_report_on));
					report_mismatch("interval_ms", 32'(interval_ms),
						32'(want.interval_ms));
					if (want.frame_valid)
						good_frames++;
					if (want.action == ACT_READ)
						reg_reads++;
				end
				results_seen++;
			end
			if (in_valid && !in_ready)
				stall_cycles++;
			if (in_valid && in_ready) begin
				results_due.push_back(predict_byte(rx_byte));
				bytes_taken++;
			end
		end
	end

	// Receiver: take every beat, except for random stall bursts while idling
	// is on and one long hold-off when asked, counted here in cycles.
	initial begin : ready_driver
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req  = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte and return at the edge that takes it. Valid is left
	// high so the next call can follow without a bubble.
	task automatic send_byte(byte_t b);
		if (idle_on && ($urandom_range(0, 5) == 0)) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	// Send "<cmd> <sep> dddd Y" with the value in decimal; bad_pos picks a
	// digit to overwrite with a random byte (NO_BAD_DIGIT keeps them all).
	task automatic send_frame(byte_t cmd, byte_t sep, int unsigned value, int bad_pos);
		byte_t       digit [FRAME_DIGITS];
		int unsigned rest;
		rest = value;
		for (int k = FRAME_DIGITS - 1; k >= 0; k--) begin
			digit[k] = byte_t'(CH_ZERO + rest % 10);
			rest     = rest / 10;
		end
		if (bad_pos < FRAME_DIGITS)
			digit[bad_pos] = byte_t'($urandom_range(0, 255));
		send_byte(cmd);
		send_byte(sep);
		for (int k = 0; k < FRAME_DIGITS; k++)
			send_byte(digit[k]);
		send_byte(CH_END);
	endtask

	// Mostly well-formed frames with random content; the rest are broken:
	// odd command byte, missing separator, bad digit, or cut short.
	task automatic send_random_frame();
		byte_t       cmd;
		byte_t       sep;
		int unsigned value;
		int          bad_pos;
		int unsigned cut;
		if ($urandom_range(0, 9) != 0)
			cmd = byte_t'(CH_CMD_LO + $urandom_range(0, 4));
		else
			cmd = byte_t'($urandom_range(0, 255));
		sep = ($urandom_range(0, 19) != 0) ? CH_SEP : byte_t'($urandom_range(0, 255));
		if ((cmd == CH_CMD_HI) && $urandom_range(0, 1))
			value = $urandom_range(0, 20);
		else if ((cmd == byte_t'(CH_ZERO + CMD_INTERVAL)) && ($urandom_range(0, 4) == 0))
			value = $urandom_range(0, 1) ? 0 : 9999;
		else
			value = $urandom_range(0, 9999);
		bad_pos = ($urandom_range(0, 19) == 0) ? $urandom_range(0, FRAME_DIGITS - 1)
			: NO_BAD_DIGIT;
		if ($urandom_range(0, 14) == 0) begin
			// truncated frame: a few bytes, then an early terminator
			cut = $urandom_range(0, 5);
			if (cut > 0)
				send_byte(cmd);
			if (cut > 1)
				send_byte(sep);
			for (int k = 2; k < cut; k++)
				send_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
			send_byte(CH_END);
		end else begin
			send_frame(cmd, sep, value, bad_pos);
		end
	endtask

	task automatic send_noise(int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			send_byte(($urandom_range(0, 7) == 0) ? CH_END : byte_t'($urandom_range(0, 255)));
	endtask

	// A terminator straight after reset meets the all-zero history, then the
	// byte extremes pass through as plain non-frame beats.
	task automatic test_reset_history();
		send_byte(CH_END);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Zero interval, a read above the last register with all nines, and a
	// frame whose separator is missing.
	task automatic test_directed_frames();
		send_frame(byte_t'(CH_ZERO + CMD_INTERVAL), CH_SEP, 0, NO_BAD_DIGIT);
		send_frame(CH_CMD_HI, CH_SEP, 9999, NO_BAD_DIGIT);
		send_frame(byte_t'(CH_ZERO + CMD_LUX), CH_END, 15, NO_BAD_DIGIT);
	endtask

	task automatic test_random_frames(int unsigned count);
		int unsigned stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				send_noise($urandom_range(1, 4));
			else
				send_random_frame();
		end
	endtask

	// Hold the receiver off for a long stretch while bytes keep coming, so
	// the pipeline fills and the input stalls.
	task automatic test_backpressure();
		int unsigned stop_at;
		idle_on  = 1'b0;
		hold_req = 1'b1;
		stop_at  = bytes_sent + 60;
		while (bytes_sent < stop_at)
			send_random_frame();
	endtask

	// Finish with no idling on either side, back to back.
	task automatic test_quiet_tail(int unsigned count);
		idle_on = 1'b0;
		test_random_frames(count);
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = '0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_history();
		test_directed_frames();
		idle_on = 1'b1;
		test_random_frames(760);
		test_backpressure();
		test_quiet_tail(150);

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d bytes (%0d taken), checked %0d results: %0d good frames, %0d reads",
			bytes_sent, bytes_taken, results_seen, good_frames, reg_reads);
		$display("Input stalled for %0d cycles under a held receiver; %0d mismatches",
			stall_cycles, mismatches);
		if ((mismatches == 0) && (results_due.size() == 0))
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/acfc_pkg.sv
rtl/ascii_command_frame_controller_unit.sv
sim/tb_ascii_command_frame_controller_unit.sv
